// ===== src/rce_pkg.sv =====
// Shared types and constants for the Roberts cross edge filter.
// No dependencies; the top level, front end, back end and testbench refer to this package by scoped names.
package rce_pkg;

  // Field widths
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int GRAD_W    = PIX_W + 1;
  localparam int SQ_W      = 2 * PIX_W;
  localparam int ENERGY_W  = SQ_W + 1;
  localparam int SQRT_STG  = (ENERGY_W + 1) / 2;

  // Defaults for the top-level parameters
  localparam int LINE_DEPTH_DEF = 1024;
  localparam int ROW_LIMIT_DEF  = 1024;
  localparam int MID_DEPTH_DEF  = 4;
  localparam int OUT_DEPTH_DEF  = 16;

  // Register reset value and register indexes
  localparam logic [CFG_W-1:0]     DIM_RESET        = CFG_W'(1024);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // Position and end-of-frame flag carried with each result
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               frame_last;
  } tag_t;

  // Item handed from the front to the back
  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    tag_t                     tag;
  } grad_item_t;

  // Finished result
  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    tag_t             tag;
  } edge_item_t;

endpackage

// ===== src/roberts_cross_edge_filter.sv =====
// Top level of the Roberts cross edge filter: front end, gradient queue, back end.
// Depends on rce_pkg, rce_front, rce_queue and rce_back.
//
//  channel   direction  handshake            payload
//  in_       input      push / full          in_pixel_value[7:0]
//  out_      output     empty / pop          out_edge_value[7:0], out_col[9:0],
//                                            out_row[9:0], out_frame_last
//  cfg_      input      cfg_we (no wait)     cfg_index[0], cfg_data[10:0]
//
// One pixel is taken per clock while full is low. A result for the pixel that
// completes its 2x2 window passes the line buffer read in the front, the
// gradient queue, then squaring, summing and nine square-root stages in the back.
// Reset is synchronous; the line buffer is not cleared, its entries are
// always written before their data is used. full rises once the gradient queue and
// the item in the line-buffer stage together reach the queue depth; the back
// end stops issuing once the result queue lacks room for every item in flight.
module roberts_cross_edge_filter #(
  parameter int LINE_DEPTH = rce_pkg::LINE_DEPTH_DEF,
  parameter int ROW_LIMIT  = rce_pkg::ROW_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rce_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic [rce_pkg::PIX_W-1:0]     in_pixel_value,
  output logic                          empty,
  input  logic                          pop,
  output logic [rce_pkg::PIX_W-1:0]     out_edge_value,
  output logic [rce_pkg::COORD_W-1:0]   out_col,
  output logic [rce_pkg::COORD_W-1:0]   out_row,
  output logic                          out_frame_last
);

  localparam int MID_DEPTH = rce_pkg::MID_DEPTH_DEF;

  logic                                mid_push, mid_pop, mid_empty;
  logic [$clog2(MID_DEPTH+1)-1:0]      mid_count;
  rce_pkg::grad_item_t                 mid_in, mid_out;
  rce_pkg::edge_item_t                 out_item;

  // Intake and gradient terms
  rce_front #(
    .LINE_DEPTH (LINE_DEPTH),
    .ROW_LIMIT  (ROW_LIMIT),
    .MID_DEPTH  (MID_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .push_i      (push),
    .pixel_i     (in_pixel_value),
    .full_o      (full),
    .mid_count_i (mid_count),
    .mid_push_o  (mid_push),
    .mid_item_o  (mid_in)
  );

  // Decouple front and back
  rce_queue #(
    .WIDTH ($bits(rce_pkg::grad_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  // Magnitude and result queue
  rce_back #(
    .OUT_DEPTH (rce_pkg::OUT_DEPTH_DEF)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item)
  );

  assign out_edge_value = out_item.edge_value;
  assign out_col        = out_item.tag.col;
  assign out_row        = out_item.tag.row;
  assign out_frame_last = out_item.tag.frame_last;

endmodule

// ===== src/rce_ram.sv =====
// Generic simple dual-port RAM with registered read (old data on a clash).
// No dependencies.
module rce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== src/rce_queue.sv =====
// Small first-in first-out queue of generic width, held in flip-flops.
// No dependencies.
module rce_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push = push_i && (count_r != CW'(DEPTH));
  assign do_pop  = pop_i && (count_r != '0);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  assign data_o  = mem_r[rd_ptr_r];
  assign empty_o = (count_r == '0);
  assign count_o = count_r;

  // Upstream must never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && (count_r == CW'(DEPTH))))
    else $error("queue pushed while full");

endmodule

// ===== src/rce_front.sv =====
// Front end: pixel intake, raster counters, line buffer and gradient terms.
// Depends on rce_pkg and rce_ram.
module rce_front #(
  parameter int LINE_DEPTH = rce_pkg::LINE_DEPTH_DEF,
  parameter int ROW_LIMIT  = rce_pkg::ROW_LIMIT_DEF,
  parameter int MID_DEPTH  = rce_pkg::MID_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we_i,
  input  logic [rce_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rce_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               push_i,
  input  logic [rce_pkg::PIX_W-1:0]          pixel_i,
  output logic                               full_o,
  input  logic [$clog2(MID_DEPTH+1)-1:0]     mid_count_i,
  output logic                               mid_push_o,
  output rce_pkg::grad_item_t                mid_item_o
);

  localparam int CW = $clog2(LINE_DEPTH);
  localparam int RW = $clog2(ROW_LIMIT);
  localparam int PW = rce_pkg::PIX_W;

  // Last valid index of a dimension after clamping to [2, limit]
  function automatic int last_index(input logic [rce_pkg::CFG_W-1:0] v, input int limit);
    int e;
    e = int'(v);
    if (e < 2) e = 2;
    if (e > limit) e = limit;
    return e - 1;
  endfunction

  logic [CW-1:0] col_last_r, col_last_nxt;
  logic [RW-1:0] row_last_r, row_last_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] ppc_r, ppc_nxt;
  logic [PW-1:0] ppr_r, ppr_nxt;

  logic          s2_valid_r;
  logic [PW-1:0] s2_px_r, s2_ppc_r;
  logic [CW-1:0] s2_col_r;
  logic [RW-1:0] s2_row_r;
  logic          s2_emit_r, s2_last_r, s2_eol_r;

  logic          accept, col_end, row_end;
  logic [PW-1:0] above;
  logic [CW-1:0] col_m1;
  logic [RW-1:0] row_m1;

  assign full_o  = (int'(mid_count_i) + int'(s2_valid_r)) >= MID_DEPTH;
  assign accept  = push_i && !full_o;
  assign col_end = (col_r == col_last_r);
  assign row_end = (row_r == row_last_r);

  // Line buffer: read the pixel above and overwrite it in the same cycle
  rce_ram #(
    .WIDTH (PW),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (col_r),
    .wdata (pixel_i),
    .re    (accept),
    .raddr (col_r),
    .rdata (above)
  );

  // Dimension registers and raster position
  always_comb begin
    col_last_nxt = col_last_r;
    row_last_nxt = row_last_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    ppc_nxt      = ppc_r;
    ppr_nxt      = ppr_r;
    if (cfg_we_i) begin
      case (cfg_index_i)
        rce_pkg::REG_IMAGE_WIDTH:  col_last_nxt = CW'(last_index(cfg_data_i, LINE_DEPTH));
        rce_pkg::REG_IMAGE_HEIGHT: row_last_nxt = RW'(last_index(cfg_data_i, ROW_LIMIT));
        default: ;
      endcase
      col_nxt = '0;
      row_nxt = '0;
      ppc_nxt = '0;
      ppr_nxt = '0;
    end else begin
      if (accept) begin
        if (col_end) begin
          col_nxt = '0;
          row_nxt = row_end ? '0 : row_r + 1'b1;
          ppc_nxt = '0;
        end else begin
          col_nxt = col_r + 1'b1;
          ppc_nxt = pixel_i;
        end
      end
      // The upper-left pixel is the previous item's pixel above
      if (s2_valid_r) begin
        ppr_nxt = s2_eol_r ? '0 : above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= CW'(last_index(rce_pkg::DIM_RESET, LINE_DEPTH));
      row_last_r <= RW'(last_index(rce_pkg::DIM_RESET, ROW_LIMIT));
      col_r      <= '0;
      row_r      <= '0;
      ppc_r      <= '0;
      ppr_r      <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      col_last_r <= col_last_nxt;
      row_last_r <= row_last_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      ppc_r      <= ppc_nxt;
      ppr_r      <= ppr_nxt;
      s2_valid_r <= accept;
    end
  end

  // Hold the accepted item while the line buffer answers
  always_ff @(posedge clk) begin
    if (accept) begin
      s2_px_r   <= pixel_i;
      s2_ppc_r  <= ppc_r;
      s2_col_r  <= col_r;
      s2_row_r  <= row_r;
      s2_emit_r <= (col_r != '0) && (row_r != '0);
      s2_last_r <= col_end && row_end;
      s2_eol_r  <= col_end;
    end
  end

  // Form the gradient pair and the output position
  assign col_m1 = s2_col_r - CW'(1);
  assign row_m1 = s2_row_r - RW'(1);

  always_comb begin
    mid_item_o.gx             = $signed({1'b0, ppr_r}) - $signed({1'b0, s2_px_r});
    mid_item_o.gy             = $signed({1'b0, s2_ppc_r}) - $signed({1'b0, above});
    mid_item_o.tag.col        = rce_pkg::COORD_W'(col_m1);
    mid_item_o.tag.row        = rce_pkg::COORD_W'(row_m1);
    mid_item_o.tag.frame_last = s2_last_r;
  end

  assign mid_push_o = s2_valid_r && s2_emit_r;

  a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s2_valid_r)
    else $error("accepted item did not reach the gradient stage");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= col_last_r)
    else $error("column counter beyond row end");

endmodule

// ===== src/rce_back.sv =====
// Back end: gradient energy, pipelined square root, saturation, result queue.
// Depends on rce_pkg and rce_queue.
module rce_back #(
  parameter int OUT_DEPTH = rce_pkg::OUT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mid_empty_i,
  input  rce_pkg::grad_item_t mid_item_i,
  output logic                mid_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output rce_pkg::edge_item_t out_item_o
);

  localparam int EW  = rce_pkg::ENERGY_W;
  localparam int NSQ = rce_pkg::SQRT_STG;
  localparam int LAT = NSQ + 2;
  localparam int IW  = $clog2(LAT + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic                         sa_valid_r;
  logic [rce_pkg::SQ_W-1:0]     sa_sqx_r, sa_sqy_r;
  rce_pkg::tag_t                sa_tag_r;
  logic                         sb_valid_r;
  logic [EW-1:0]                sb_v_r;
  rce_pkg::tag_t                sb_tag_r;
  logic                         sq_valid_r [NSQ];
  logic [EW-1:0]                sq_v_r     [NSQ];
  logic [EW-1:0]                sq_root_r  [NSQ];
  rce_pkg::tag_t                sq_tag_r   [NSQ];

  logic signed [2*rce_pkg::GRAD_W-1:0] sqx, sqy;
  logic [IW-1:0]                inflight_r, inflight_nxt;
  logic [OCW-1:0]               out_count;
  logic                         done;
  logic [EW-1:0]                root_fin;
  rce_pkg::edge_item_t          fin_item;

  // Issue only while the result queue has room for everything in flight
  assign mid_pop_o = !mid_empty_i && ((int'(out_count) + int'(inflight_r)) < OUT_DEPTH);
  assign done      = sq_valid_r[NSQ-1];

  always_comb begin
    inflight_nxt = inflight_r;
    if (mid_pop_o && !done) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (done && !mid_pop_o) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  // Square both gradients, then sum
  assign sqx = mid_item_i.gx * mid_item_i.gx;
  assign sqy = mid_item_i.gy * mid_item_i.gy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
      sa_valid_r <= 1'b0;
      sb_valid_r <= 1'b0;
    end else begin
      inflight_r <= inflight_nxt;
      sa_valid_r <= mid_pop_o;
      sb_valid_r <= sa_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    sa_sqx_r <= sqx[rce_pkg::SQ_W-1:0];
    sa_sqy_r <= sqy[rce_pkg::SQ_W-1:0];
    sa_tag_r <= mid_item_i.tag;
    sb_v_r   <= {1'b0, sa_sqx_r} + {1'b0, sa_sqy_r};
    sb_tag_r <= sa_tag_r;
  end

  // Square root, one result bit per stage
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [EW-1:0] BIT = EW'(1) << (2 * (NSQ - 1 - k));
    logic          valid_in;
    logic [EW-1:0] v_in, root_in;
    logic [EW:0]   trial;
    rce_pkg::tag_t tag_in;

    if (k == 0) begin : g_first
      assign valid_in = sb_valid_r;
      assign v_in     = sb_v_r;
      assign root_in  = '0;
      assign tag_in   = sb_tag_r;
    end else begin : g_next
      assign valid_in = sq_valid_r[k-1];
      assign v_in     = sq_v_r[k-1];
      assign root_in  = sq_root_r[k-1];
      assign tag_in   = sq_tag_r[k-1];
    end

    assign trial = {1'b0, root_in} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[k] <= 1'b0;
      end else begin
        sq_valid_r[k] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      sq_tag_r[k] <= tag_in;
      if (trial <= {1'b0, v_in}) begin
        sq_v_r[k]    <= v_in - trial[EW-1:0];
        sq_root_r[k] <= (root_in >> 1) + BIT;
      end else begin
        sq_v_r[k]    <= v_in;
        sq_root_r[k] <= root_in >> 1;
      end
    end
  end

  // Saturate and queue the result
  assign root_fin = sq_root_r[NSQ-1];

  always_comb begin
    fin_item.edge_value = (root_fin > EW'(rce_pkg::PIX_MAX)) ? rce_pkg::PIX_MAX
                                                             : root_fin[rce_pkg::PIX_W-1:0];
    fin_item.tag        = sq_tag_r[NSQ-1];
  end

  rce_queue #(
    .WIDTH ($bits(rce_pkg::edge_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (done),
    .data_i  (fin_item),
    .pop_i   (pop_i),
    .data_o  (out_item_o),
    .empty_o (empty_o),
    .count_o (out_count)
  );

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(out_count) + int'(inflight_r)) <= OUT_DEPTH)
    else $error("items in flight exceed result queue room");

endmodule

// ===== tb/tb_roberts_cross_edge_filter.sv =====
// Self-checking testbench for roberts_cross_edge_filter: queue-style pixel input,
// queue-style edge results and the dimension register port. Depends on rce_pkg
// and the RTL under src/.
module tb_roberts_cross_edge_filter;

  localparam int          LINE_MAX     = rce_pkg::LINE_DEPTH_DEF;
  localparam int          ROW_MAX      = rce_pkg::ROW_LIMIT_DEF;
  localparam int          SETTLE_CYC   = 32;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          RAND_PIXELS  = 420;
  localparam int          PROBE_PIXELS = 40;

  typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_NEAR} pix_mode_e;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [rce_pkg::CFG_IDX_W-1:0] cfg_index = rce_pkg::REG_IMAGE_WIDTH;
  logic [rce_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          push = 1'b0;
  logic                          full;
  logic [rce_pkg::PIX_W-1:0]     in_pixel_value = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic [rce_pkg::PIX_W-1:0]     out_edge_value;
  logic [rce_pkg::COORD_W-1:0]   out_col;
  logic [rce_pkg::COORD_W-1:0]   out_row;
  logic                          out_frame_last;

  // Pixels waiting to be driven and edge results waiting to be seen
  logic [rce_pkg::PIX_W-1:0] pend_q[$];
  rce_pkg::edge_item_t       edge_exp_q[$];

  // Predictor state: line of the row above, left and upper-left pixels, counters
  logic [rce_pkg::PIX_W-1:0] row_above_mem [LINE_MAX];
  logic [rce_pkg::PIX_W-1:0] left_pix = '0;
  logic [rce_pkg::PIX_W-1:0] diag_pix = '0;
  int unsigned               col_pos = 0;
  int unsigned               row_pos = 0;
  logic [rce_pkg::CFG_W-1:0] width_reg = rce_pkg::DIM_RESET;
  logic [rce_pkg::CFG_W-1:0] height_reg = rce_pkg::DIM_RESET;

  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          fail_cnt = 0;
  int          pix_sent = 0;
  int          edge_checked = 0;
  int          dim_settings = 0;
  int unsigned cycle_cnt = 0;

  roberts_cross_edge_filter u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .in_pixel_value (in_pixel_value),
    .empty          (empty),
    .pop            (pop),
    .out_edge_value (out_edge_value),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_frame_last (out_frame_last)
  );

  // Clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp a dimension register to the range the block works in
  function automatic int unsigned eff_dim(input logic [rce_pkg::CFG_W-1:0] v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // Floor square root, bit by bit from the top
  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 8; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Idle share of one side: none, some or a lot
  function automatic int pick_idle();
    case ($urandom_range(2))
      0: return 0;
      1: return 20;
      default: return 60;
    endcase
  endfunction

  // Gap length: mostly short, now and then long
  function automatic int draw_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [rce_pkg::PIX_W-1:0] draw_pixel(input pix_mode_e mode);
    case (mode)
      PIX_EXTREME: return $urandom_range(1) ? rce_pkg::PIX_MAX : '0;
      PIX_NEAR:    return rce_pkg::PIX_W'($urandom_range(100, 140));
      default:     return rce_pkg::PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Work out the edge result, if any, that one accepted pixel causes
  task automatic predict_edge(input logic [rce_pkg::PIX_W-1:0] px);
    int unsigned         w;
    int unsigned         h;
    int unsigned         c;
    int unsigned         r;
    int unsigned         mag;
    int                  gx;
    int                  gy;
    logic [rce_pkg::PIX_W-1:0] above;
    rce_pkg::edge_item_t e;
    w = eff_dim(width_reg, LINE_MAX);
    h = eff_dim(height_reg, ROW_MAX);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    above = row_above_mem[c];
    if (r >= 1 && c >= 1) begin
      gx = int'(diag_pix) - int'(px);
      gy = int'(left_pix) - int'(above);
      mag = floor_root(gx * gx + gy * gy);
      e.edge_value     = (mag > 255) ? rce_pkg::PIX_MAX : mag[rce_pkg::PIX_W-1:0];
      e.tag.col        = rce_pkg::COORD_W'(c - 1);
      e.tag.row        = rce_pkg::COORD_W'(r - 1);
      e.tag.frame_last = (r == h - 1) && (c == w - 1);
      edge_exp_q.push_back(e);
    end
    diag_pix = above;
    left_pix = px;
    row_above_mem[c] = px;
    // Advance the raster position; a row end clears the window
    if (c + 1 >= w) begin
      col_pos  = 0;
      left_pix = '0;
      diag_pix = '0;
      row_pos  = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  task automatic restart_frame_pred();
    col_pos  = 0;
    row_pos  = 0;
    left_pix = '0;
    diag_pix = '0;
  endtask

  // Write one or both dimension registers; each write restarts the frame
  task automatic set_dims(input logic [rce_pkg::CFG_W-1:0] w,
                          input logic [rce_pkg::CFG_W-1:0] h,
                          input bit wr_w, input bit wr_h);
    if (wr_w) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= rce_pkg::REG_IMAGE_WIDTH;
      cfg_data  <= w;
      width_reg = w;
      restart_frame_pred();
    end
    if (wr_h) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= rce_pkg::REG_IMAGE_HEIGHT;
      cfg_data  <= h;
      height_reg = h;
      restart_frame_pred();
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_settings++;
  endtask

  task automatic queue_pixels(input int n, input pix_mode_e mode);
    @(negedge clk);
    repeat (n) pend_q.push_back(draw_pixel(mode));
  endtask

  // Hold until every pixel is taken and every result seen, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk);
    while (pend_q.size() != 0 || push || edge_exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Pixel driver: hold an item until taken, then advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      push   <= 1'b0;
      in_gap <= 0;
    end else begin
      if (push && !full) begin
        predict_edge(in_pixel_value);
        pix_sent++;
      end
      if (!push || !full) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          push   <= 1'b0;
        end else if (pend_q.size() > 0) begin
          push           <= 1'b1;
          in_pixel_value <= pend_q.pop_front();
          in_gap         <= draw_gap(in_idle_pct);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken item with the oldest expectation
  always @(posedge clk) begin : result_mon
    rce_pkg::edge_item_t exp_e;
    if (!rst_n) begin
      pop     <= 1'b0;
      out_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (edge_exp_q.size() == 0) begin
          $error("unexpected edge result: value %0d col %0d row %0d last %0d",
                 out_edge_value, out_col, out_row, out_frame_last);
          fail_cnt++;
        end else begin
          exp_e = edge_exp_q.pop_front();
          edge_checked++;
          if (out_edge_value !== exp_e.edge_value) begin
            $error("edge_value: expected %0d, got %0d", exp_e.edge_value, out_edge_value);
            fail_cnt++;
          end
          if (out_col !== exp_e.tag.col) begin
            $error("out_col: expected %0d, got %0d", exp_e.tag.col, out_col);
            fail_cnt++;
          end
          if (out_row !== exp_e.tag.row) begin
            $error("out_row: expected %0d, got %0d", exp_e.tag.row, out_row);
            fail_cnt++;
          end
          if (out_frame_last !== exp_e.tag.frame_last) begin
            $error("frame_last: expected %0d, got %0d", exp_e.tag.frame_last, out_frame_last);
            fail_cnt++;
          end
        end
      end
      // Stall at random, otherwise keep pop high
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        pop     <= 1'b0;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(99) < out_idle_pct) out_gap <= draw_gap(100);
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("roberts_cross_edge_filter test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [rce_pkg::CFG_W-1:0] w;
    logic [rce_pkg::CFG_W-1:0] h;
    int                        sel;
    int                        n;
    int                        frame_px;
    int                        rand_pixels;
    pix_mode_e                 mode;
    rand_pixels = 0;
    for (int i = 0; i < LINE_MAX; i++) row_above_mem[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset dimensions: a stretch of the first row, which gives no result
    in_idle_pct  = 10;
    out_idle_pct = 10;
    queue_pixels(PROBE_PIXELS, PIX_UNIFORM);
    wait_drained();

    // Smallest frame, largest gradient of both signs, frame end on every result
    set_dims(11'd2, 11'd2, 1'b1, 1'b1);
    @(negedge clk);
    pend_q.push_back(8'd255); pend_q.push_back(8'd0);
    pend_q.push_back(8'd255); pend_q.push_back(8'd0);
    pend_q.push_back(8'd0);   pend_q.push_back(8'd255);
    pend_q.push_back(8'd0);   pend_q.push_back(8'd255);
    wait_drained();

    // Dimensions below range act as two
    set_dims(11'd0, 11'd1, 1'b1, 1'b1);
    @(negedge clk);
    pend_q.push_back(8'd0);   pend_q.push_back(8'd255);
    pend_q.push_back(8'd255); pend_q.push_back(8'd0);
    wait_drained();

    // Rewrite of an unchanged width restarts the frame part way through
    set_dims(11'd3, 11'd3, 1'b1, 1'b1);
    @(negedge clk);
    pend_q.push_back(8'd10);  pend_q.push_back(8'd200);
    pend_q.push_back(8'd30);  pend_q.push_back(8'd90);
    wait_drained();
    set_dims(11'd3, 11'd3, 1'b1, 1'b0);
    queue_pixels(9, PIX_UNIFORM);
    wait_drained();

    // Register values past the top of the range, partial frames
    set_dims(11'd2047, 11'd2, 1'b1, 1'b1);
    queue_pixels(PROBE_PIXELS, PIX_UNIFORM);
    wait_drained();
    set_dims(11'd2, 11'd2047, 1'b1, 1'b1);
    queue_pixels(PROBE_PIXELS, PIX_EXTREME);
    wait_drained();

    // Random small frames, whole and broken, with mixed idling
    while (rand_pixels < RAND_PIXELS) begin
      case ($urandom_range(9))
        0: w = rce_pkg::CFG_W'($urandom_range(0, 1));
        1: w = rce_pkg::CFG_W'($urandom_range(13, 24));
        default: w = rce_pkg::CFG_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(9))
        0: h = rce_pkg::CFG_W'($urandom_range(0, 1));
        1: h = rce_pkg::CFG_W'($urandom_range(7, 10));
        default: h = rce_pkg::CFG_W'($urandom_range(2, 6));
      endcase
      sel = $urandom_range(3);
      set_dims(w, h, sel != 1, sel != 0);
      frame_px = eff_dim(width_reg, LINE_MAX) * eff_dim(height_reg, ROW_MAX);
      n = frame_px * $urandom_range(1, 2);
      if ($urandom_range(3) == 0) n = $urandom_range(1, frame_px + frame_px / 2);
      if (n > RAND_PIXELS - rand_pixels) n = RAND_PIXELS - rand_pixels;
      mode = pix_mode_e'($urandom_range(2));
      in_idle_pct  = pick_idle();
      out_idle_pct = pick_idle();
      // Pause the sender until all results are in: always first, then now and then
      if (rand_pixels == 0 || $urandom_range(3) == 0) begin
        queue_pixels(n / 2, mode);
        wait_drained();
        queue_pixels(n - n / 2, mode);
      end else begin
        queue_pixels(n, mode);
      end
      wait_drained();
      rand_pixels += n;
    end

    $display("Sent %0d pixels under %0d dimension settings and checked %0d edge results,",
             pix_sent, dim_settings, edge_checked);
    $display("from 2x2 frames to partial frames at the reset and the largest dimensions.");
    if (fail_cnt == 0) begin
      $display("roberts_cross_edge_filter test passed");
    end else begin
      $display("roberts_cross_edge_filter test failed");
    end
    $finish;
  end

endmodule
